// ===== rtl/core/rspe_pkg.sv =====
`default_nettype none

package rspe_pkg;

    // Code shape
    localparam int unsigned NPAR        = 16;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned PARITY_W    = NPAR * SYM_W;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Field polynomial x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [SYM_W:0] FIELD_POLY = 9'h11D;

    // Generator coefficients, x^15 term first (monic x^16 term implied)
    localparam logic [SYM_W-1:0] GEN_COEF [NPAR] = '{
        8'd59,  8'd13, 8'd104, 8'd189, 8'd68, 8'd209, 8'd30, 8'd8,
        8'd163, 8'd65, 8'd41,  8'd229, 8'd98, 8'd50,  8'd36, 8'd59
    };

    // Parity of one block, byte k (k = 0 highest order) in bits [8k+7:8k]
    typedef logic [PARITY_W-1:0] parity_word_t;
    typedef logic [SYM_W-1:0]    sym_t;

    // Front to queue: one finished block
    typedef struct packed {
        logic         push;
        parity_word_t word;
    } blk_push_t;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // GF(256) product, shift and add modulo the field polynomial
    function automatic sym_t gf_mul(input sym_t a_in, input sym_t b_in);
        sym_t a;
        sym_t acc;
        a   = a_in;
        acc = '0;
        for (int k = 0; k < SYM_W; k++) begin
            if (b_in[k]) begin
                acc = acc ^ a;
            end
            a = {a[SYM_W-2:0], 1'b0} ^ (a[SYM_W-1] ? FIELD_POLY[SYM_W-1:0] : '0);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rspe_lfsr.sv =====
`default_nettype none

// Front end: byte-wide LFSR division by g(x), hands off a block's parity
module rspe_lfsr (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_fire,
    input  wire rspe_pkg::sym_t       in_data,
    input  wire logic                 in_last,
    output rspe_pkg::blk_push_t       blk_out
);

    localparam int unsigned NPAR = rspe_pkg::NPAR;
    localparam int unsigned SW   = rspe_pkg::SYM_W;

    rspe_pkg::sym_t rem_reg  [NPAR];
    rspe_pkg::sym_t rem_next [NPAR];
    rspe_pkg::sym_t fb;

    // Remainder update for the incoming byte
    always_comb begin
        fb = in_data ^ rem_reg[0];
        for (int k = 0; k < NPAR - 1; k++) begin
            rem_next[k] = rem_reg[k+1] ^ rspe_pkg::gf_mul(rspe_pkg::GEN_COEF[k], fb);
        end
        rem_next[NPAR-1] = rspe_pkg::gf_mul(rspe_pkg::GEN_COEF[NPAR-1], fb);
    end

    // Finished block goes straight to the queue
    always_comb begin
        blk_out.push = in_fire && in_last;
        for (int k = 0; k < NPAR; k++) begin
            blk_out.word[k*SW +: SW] = rem_next[k];
        end
    end

    // Remainder register, cleared at reset and after each block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NPAR; k++) begin
                rem_reg[k] <= '0;
            end
        end else if (in_fire) begin
            for (int k = 0; k < NPAR; k++) begin
                rem_reg[k] <= in_last ? '0 : rem_next[k];
            end
        end
    end

    // A block end always leaves a clean remainder
    a_clear_after_block: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_last |=> rem_reg[0] == '0 && rem_reg[NPAR-1] == '0)
        else $error("remainder not cleared after block end");

    // Feedback zero means a plain shift of the remainder
    a_zero_feedback: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !in_last && fb == '0 |=> rem_reg[NPAR-1] == '0)
        else $error("remainder tail not zero after zero feedback");

    // Handoff only on an accepted last byte
    a_push_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        blk_out.push |-> in_fire && in_last)
        else $error("parity handed off without block end");

endmodule

`default_nettype wire

// ===== rtl/core/rspe_queue.sv =====
`default_nettype none

// Small queue of finished parity blocks between front and back
module rspe_queue #(
    parameter int unsigned DEPTH = rspe_pkg::QUEUE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire rspe_pkg::blk_push_t    blk_in,
    input  wire logic                   pop,
    output rspe_pkg::parity_word_t      head_word,
    output rspe_pkg::q_status_t         status
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    rspe_pkg::parity_word_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = blk_in.push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_word    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= blk_in.word;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        blk_in.push |-> !status.full)
        else $error("parity block pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/rspe_serial.sv =====
`default_nettype none

// Back end: sends one parity block as 16 byte transfers, highest order first
module rspe_serial (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire rspe_pkg::q_status_t    q_status,
    input  wire rspe_pkg::parity_word_t q_word,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output rspe_pkg::sym_t              m_tdata,
    output logic                        m_tlast
);

    localparam int unsigned NPAR = rspe_pkg::NPAR;
    localparam int unsigned SW   = rspe_pkg::SYM_W;
    localparam int unsigned NW   = $clog2(NPAR);

    rspe_pkg::parity_word_t word_reg, word_next;
    logic [NW-1:0]          cnt_reg,  cnt_next;
    logic                   valid_reg, valid_next;
    logic                   last_byte;
    logic                   out_fire;

    assign last_byte = (cnt_reg == NW'(NPAR - 1));
    assign out_fire  = valid_reg && m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = word_reg[SW-1:0];
    assign m_tlast   = last_byte;

    // Load a new block when idle or as the final byte leaves
    always_comb begin
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        q_pop      = 1'b0;
        if (!valid_reg || (out_fire && last_byte)) begin
            if (!q_status.empty) begin
                q_pop      = 1'b1;
                word_next  = q_word;
                cnt_next   = '0;
                valid_next = 1'b1;
            end else begin
                cnt_next   = '0;
                valid_next = 1'b0;
            end
        end else if (out_fire) begin
            word_next = {{SW{1'b0}}, word_reg[rspe_pkg::PARITY_W-1:SW]};
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // Mid-block the output must stay valid
    a_cnt_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 |-> valid_reg)
        else $error("byte count advanced with no block loaded");

    // Byte count steps by one per transfer inside a block
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && !last_byte |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("byte count did not advance");

    // A new block is taken only at a block boundary
    a_pop_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !valid_reg || (out_fire && last_byte))
        else $error("queue popped mid-block");

endmodule

`default_nettype wire

// ===== rtl/core/reed_solomon_parity_encoder.sv =====
`default_nettype none

// Reed-Solomon parity encoder, GF(256) with polynomial 0x11D and the fixed
// degree-16 generator. Data bytes enter on the s_ stream, one per cycle while
// s_tready is high, s_tlast marking a block's last byte; blocks have any length
// of one byte or more. A block's 16 parity bytes leave on the m_ stream highest
// order first, m_tlast on the sixteenth. When the output side is free, the
// finished parity word is first written into the queue and then loaded into
// the serializer register, after which the first parity byte is valid. The
// input LFSR takes one byte per cycle while s_tready is high; the output
// serializer sends one parity byte per cycle while m_tready is high. Finished
// blocks wait in a queue of QUEUE_DEPTH parity words; while that queue is full
// s_tready is low, so a stream of blocks shorter than 16 bytes is paced by the
// output side.
module reed_solomon_parity_encoder #(
    parameter int unsigned QUEUE_DEPTH = rspe_pkg::QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] data_byte
    input  wire logic       s_tlast,    // block_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] parity_byte
    output logic            m_tlast     // parity_last
);

    rspe_pkg::blk_push_t    blk;
    rspe_pkg::q_status_t    q_status;
    rspe_pkg::parity_word_t q_word;
    logic                   q_pop;
    logic                   in_fire;

    assign s_tready = !q_status.full;
    assign in_fire  = s_tvalid && s_tready;

    rspe_lfsr u_lfsr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_data (s_tdata),
        .in_last (s_tlast),
        .blk_out (blk)
    );

    rspe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .blk_in    (blk),
        .pop       (q_pop),
        .head_word (q_word),
        .status    (q_status)
    );

    rspe_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_word   (q_word),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
